### hw/rtl/assert_macros.svh
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk_sig, rstn_sig, prop, msg) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
        else $error(msg);

// Assertion on the local clk / rst_n pair.
`define ASSERT_STD(lbl, prop, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`endif

### hw/rtl/utf8b_pkg.sv
package utf8b_pkg;

    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_END     = 2'd1,
        ST_BUDGET  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  LEAD4      = 8'hF0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [7:0]  CONT_MASK  = 8'h3F;
    localparam logic [31:0] MAX_1BYTE  = 32'h0000_007F;
    localparam logic [31:0] MAX_2BYTE  = 32'h0000_07FF;
    localparam logic [31:0] MAX_3BYTE  = 32'h0000_FFFF;
    localparam logic [31:0] MAX_CP     = 32'h0010_FFFF;
    localparam logic [15:0] BUDGET_RST = 16'hFFFF;

    // Results for one code point, ready to be shifted out.
    typedef struct packed {
        status_t          status;
        logic [1:0]       last_idx;
        logic [3:0][7:0]  bytes;
        logic [3:0][15:0] totals;
    } enc_result_t;

endpackage

### hw/rtl/utf8b_encode.sv
module utf8b_encode
    import utf8b_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic [31:0]            code_point,
    input  logic                   start_string,
    input  logic [15:0]            byte_budget,
    input  logic [COUNT_WIDTH-1:0] byte_count,
    input  logic                   stopped,
    output enc_result_t            result,
    output logic [COUNT_WIDTH-1:0] count_next,
    output logic                   stopped_next
);

    localparam int CW = COUNT_WIDTH;

    function automatic logic [15:0] to16(input logic [CW:0] v);
        logic [CW+16:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    logic [CW-1:0]  cnt_eff;
    logic           stop_eff;
    logic [2:0]     size;
    logic [1:0]     last_idx;
    logic [3:0][7:0] bytes;
    logic           invalid;
    logic [CW:0]    next_cnt;
    logic           over_budget;

    assign cnt_eff  = start_string ? '0 : byte_count;
    assign stop_eff = start_string ? 1'b0 : stopped;

    always_comb
    begin
        bytes    = '0;
        size     = 3'd1;
        last_idx = 2'd0;
        invalid  = 1'b0;
        if (code_point <= MAX_1BYTE)
        begin
            bytes[0] = code_point[7:0];
        end
        else if (code_point <= MAX_2BYTE)
        begin
            size     = 3'd2;
            last_idx = 2'd1;
            bytes[0] = LEAD2 | {3'b0, code_point[10:6]};
            bytes[1] = CONT | ({2'b0, code_point[5:0]} & CONT_MASK);
        end
        else if (code_point <= MAX_3BYTE)
        begin
            size     = 3'd3;
            last_idx = 2'd2;
            bytes[0] = LEAD3 | {4'b0, code_point[15:12]};
            bytes[1] = CONT | ({2'b0, code_point[11:6]} & CONT_MASK);
            bytes[2] = CONT | ({2'b0, code_point[5:0]} & CONT_MASK);
        end
        else if (code_point <= MAX_CP)
        begin
            size     = 3'd4;
            last_idx = 2'd3;
            bytes[0] = LEAD4 | {5'b0, code_point[20:18]};
            bytes[1] = CONT | ({2'b0, code_point[17:12]} & CONT_MASK);
            bytes[2] = CONT | ({2'b0, code_point[11:6]} & CONT_MASK);
            bytes[3] = CONT | ({2'b0, code_point[5:0]} & CONT_MASK);
        end
        else
        begin
            invalid = 1'b1;
        end
    end

    assign next_cnt    = {1'b0, cnt_eff} + {{(CW-2){1'b0}}, size};
    assign over_budget = next_cnt[CW] ||
                         ({16'b0, next_cnt} > {{(CW+1){1'b0}}, byte_budget});

    always_comb
    begin
        logic [CW:0] sum;
        result.status   = ST_BYTE;
        result.last_idx = last_idx;
        result.bytes    = bytes;
        result.totals   = '0;
        count_next      = cnt_eff;
        stopped_next    = stop_eff;
        for (int k = 0; k < 4; k++)
        begin
            sum = {1'b0, cnt_eff} + (CW+1)'(k + 1);
            result.totals[k] = to16(sum);
        end
        if (stop_eff || code_point == 32'd0 || invalid || over_budget)
        begin
            // single status result, no bytes
            result.last_idx  = 2'd0;
            result.bytes     = '0;
            result.totals[0] = to16({1'b0, cnt_eff});
            stopped_next     = 1'b1;
            if (stop_eff || code_point == 32'd0)
                result.status = ST_END;
            else if (invalid)
                result.status = ST_INVALID;
            else
                result.status = ST_BUDGET;
        end
        else
        begin
            count_next = next_cnt[CW-1:0];
        end
    end

endmodule

### hw/rtl/utf8b_out_buf.sv
`include "assert_macros.svh"

module utf8b_out_buf
    import utf8b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  enc_result_t result,
    output logic        free,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], total_len[23:8]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    enc_result_t res_reg;
    logic        last;
    logic        take;

    assign last  = (idx_reg == res_reg.last_idx);
    assign take  = valid_reg && m_axis_tready;
    assign free  = !valid_reg || (take && last);

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {res_reg.totals[idx_reg], res_reg.bytes[idx_reg]};
    assign m_axis_tlast  = last;
    assign m_axis_tuser  = res_reg.status;

    `ASSERT_STD(a_idx_in_range, valid_reg |-> (idx_reg <= res_reg.last_idx),
        "byte index past last result")
    `ASSERT_STD(a_status_single, (valid_reg && res_reg.status != ST_BYTE) |->
        (res_reg.last_idx == 2'd0), "status request with more than one result")
    `ASSERT_STD(a_step, (take && !last) |=>
        (valid_reg && idx_reg == $past(idx_reg) + 2'd1), "byte index did not advance")
    `ASSERT_STD(a_no_overwrite, (load && valid_reg) |-> (take && last),
        "pending request overwritten")

endmodule

### hw/rtl/utf8_encoder_with_byte_budget.sv
// UTF-8 encoder with a per-string byte budget.
// Input channel s_axis: one code point per request in tdata[31:0]; tuser set
// clears the byte count and the stop flag before the code point is handled.
// Output channel m_axis: one request per encoded byte, tdata[7:0] the byte,
// tdata[23:8] the running string length, tuser the status (0 byte, 1 end of
// string, 2 budget exhausted, 3 invalid code point), tlast on the final
// request for a code point. Status requests carry no byte and are always last.
// cfg channel: writes the byte budget; always ready, write only while idle.
// m_axis_tvalid rises once the code point has passed the input register and
// been loaded into the output buffer, which then offers the first request.
// Throughput: the single output buffer shifts out one request per cycle while
// m_axis_tready is high. One-byte code points are taken back to back; a longer
// one holds off the next input until its last byte has been taken.
// Reset: clears byte count and stop flag, budget returns to 65535, both
// pipeline registers empty. When the receiver stalls, the output request
// holds, one code point waits in the input register, then tready drops.
module utf8_encoder_with_byte_budget
    import utf8b_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // code_point[31:0]
    input  logic        s_axis_tuser,   // start_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte[7:0], total_len[23:8]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                   in_valid_reg;
    logic [31:0]            cp_reg;
    logic                   start_reg;
    logic [15:0]            budget_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic                   stopped_reg;
    logic                   stopped_next;
    logic                   buf_free;
    logic                   load;
    enc_result_t            enc_res;

    assign load          = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || buf_free;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            budget_reg   <= BUDGET_RST;
            count_reg    <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (cfg_valid)
                budget_reg <= cfg_data;
            if (load)
            begin
                count_reg   <= count_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cp_reg    <= s_axis_tdata;
            start_reg <= s_axis_tuser;
        end
    end

    utf8b_encode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_encode (
        .code_point   (cp_reg),
        .start_string (start_reg),
        .byte_budget  (budget_reg),
        .byte_count   (count_reg),
        .stopped      (stopped_reg),
        .result       (enc_res),
        .count_next   (count_next),
        .stopped_next (stopped_next)
    );

    utf8b_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .result        (enc_res),
        .free          (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### tb/sv/tb_utf8_encoder_with_byte_budget.sv
`timescale 1ns / 100ps

module tb_utf8_encoder_with_byte_budget;
    import utf8b_pkg::*;

    typedef struct packed {
        logic [7:0]  octet;
        logic        is_last;
        status_t     status;
        logic [15:0] total;
    } enc_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predictor state
    logic [15:0] budget;
    logic [15:0] str_len;
    logic        str_stopped;

    enc_out_t    expected_bytes[$];
    enc_out_t    want;
    int unsigned mismatch_count;
    bit          no_idle;

    utf8_encoder_with_byte_budget dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void push_status(input status_t code);
        expected_bytes.push_back('{octet: 8'h00, is_last: 1'b1, status: code,
                                   total: str_len});
    endfunction

    function automatic void encode_code_point(input logic [31:0] cp, input logic start);
        logic [7:0]  seq [4];
        int unsigned nbytes;
        logic [16:0] next_len;
        if (start)
        begin
            str_len     = '0;
            str_stopped = 1'b0;
        end
        if (str_stopped)
        begin
            push_status(ST_END);
            return;
        end
        if (cp == 32'd0)
        begin
            str_stopped = 1'b1;
            push_status(ST_END);
            return;
        end
        if (cp <= MAX_1BYTE)
        begin
            nbytes = 1;
            seq[0] = cp[7:0];
        end
        else if (cp <= MAX_2BYTE)
        begin
            nbytes = 2;
            seq[0] = LEAD2 | {3'b000, cp[10:6]};
        end
        else if (cp <= MAX_3BYTE)
        begin
            nbytes = 3;
            seq[0] = LEAD3 | {4'b0000, cp[15:12]};
        end
        else if (cp <= MAX_CP)
        begin
            nbytes = 4;
            seq[0] = LEAD4 | {5'b00000, cp[20:18]};
        end
        else
        begin
            str_stopped = 1'b1;
            push_status(ST_INVALID);
            return;
        end
        for (int k = 1; k < nbytes; k++)
            seq[k] = CONT | (8'(cp >> (6 * (nbytes - 1 - k))) & CONT_MASK);
        next_len = {1'b0, str_len} + 17'(nbytes);
        if (next_len > {1'b0, budget} || next_len > 17'h0FFFF)
        begin
            str_stopped = 1'b1;
            push_status(ST_BUDGET);
            return;
        end
        for (int k = 0; k < nbytes; k++)
            expected_bytes.push_back('{octet: seq[k], is_last: (k + 1 == nbytes),
                                       status: ST_BYTE, total: str_len + 16'(k + 1)});
        str_len = next_len[15:0];
    endfunction

    task automatic send_code_point(input logic [31:0] cp, input logic start);
        if (!no_idle && $urandom_range(99) < 27)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cp;
        s_axis_tuser  <= start;
        encode_code_point(cp, start);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_budget(input logic [15:0] value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        budget = value;
        @(posedge clk);
    endtask

    function automatic logic [31:0] random_code_point();
        case ($urandom_range(19))
            0:       return 32'd0;
            1:       return $urandom_range(32'hFFFF_FFFF, 32'h0011_0000);
            2, 3, 4: return $urandom_range(32'h7F, 32'h1);
            5, 6, 7: return $urandom_range(32'h7FF, 32'h80);
            8, 9, 10, 11: return $urandom_range(32'hFFFF, 32'h800);
            default: return $urandom_range(32'h10_FFFF, 32'h1_0000);
        endcase
    endfunction

    task automatic test_size_boundaries();
        send_code_point(32'h0000_0041, 1'b1);
        send_code_point(32'h0000_007F, 1'b0);
        send_code_point(32'h0000_0080, 1'b0);
        send_code_point(32'h0000_07FF, 1'b0);
        send_code_point(32'h0000_0800, 1'b0);
        send_code_point(32'h0000_D800, 1'b0);
        send_code_point(32'h0000_FFFF, 1'b0);
        send_code_point(32'h0001_0000, 1'b0);
        send_code_point(32'h0010_FFFF, 1'b0);
        send_code_point(32'h0000_0001, 1'b0);
    endtask

    task automatic test_string_end();
        send_code_point(32'h0000_0000, 1'b0);
        send_code_point(32'h0000_0041, 1'b0);
        send_code_point(32'h0000_0042, 1'b1);
        send_code_point(32'h0011_0000, 1'b0);
        send_code_point(32'h0000_007F, 1'b0);
        send_code_point(32'hFFFF_FFFF, 1'b1);
        send_code_point(32'h0000_0000, 1'b1);
    endtask

    task automatic test_budget_limit();
        write_budget(16'h0000);
        send_code_point(32'h0000_0041, 1'b1);
        write_budget(16'd5);
        send_code_point(32'h0000_20AC, 1'b1);
        send_code_point(32'h0000_00E9, 1'b0);
        send_code_point(32'h0000_0041, 1'b0);
        send_code_point(32'h0001_F600, 1'b1);
        send_code_point(32'h0000_0080, 1'b0);
        write_budget(16'hFFFF);
        send_code_point(32'h0001_F600, 1'b1);
    endtask

    task automatic test_random_strings();
        logic [15:0] b;
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(5))
                0:       b = 16'h0000;
                1:       b = 16'hFFFF;
                default: b = 16'($urandom_range(48, 1));
            endcase
            if (phase == 0)
                b = 16'h0000;
            else if (phase == 1)
                b = 16'hFFFF;
            write_budget(b);
            no_idle = (phase == 2);
            send_code_point(random_code_point(), 1'b1);
            for (int n = 0; n < 13; n++)
                send_code_point(random_code_point(), $urandom_range(99) < 10);
            no_idle = 1'b0;
        end
    endtask

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            m_axis_tready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected request data %h user %0d last %b",
                                          m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata[7:0] !== want.octet)
                    report_mismatch($sformatf("byte %h, want %h",
                                              m_axis_tdata[7:0], want.octet));
                if (m_axis_tdata[23:8] !== want.total)
                    report_mismatch($sformatf("length %0d, want %0d",
                                              m_axis_tdata[23:8], want.total));
                if (m_axis_tuser !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tuser, want.status));
                if (m_axis_tlast !== want.is_last)
                    report_mismatch($sformatf("tlast %b, want %b",
                                              m_axis_tlast, want.is_last));
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        no_idle        = 1'b0;
        mismatch_count = 0;
        budget         = BUDGET_RST;
        str_len        = '0;
        str_stopped    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_size_boundaries();
        test_string_end();
        test_budget_limit();
        test_random_strings();

        wait_all_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/utf8b_pkg.sv
hw/rtl/utf8b_encode.sv
hw/rtl/utf8b_out_buf.sv
hw/rtl/utf8_encoder_with_byte_budget.sv
tb/sv/tb_utf8_encoder_with_byte_budget.sv
